// File: sv/sei_pkg.sv
// ----------------------------------------------------------------------------
// SEI framer package
// Shared payload types, controller states, command and status bundles, and
// byte constants for the SEI user-data-unregistered NAL unit framer.
// ----------------------------------------------------------------------------
package sei_pkg;

  // Input item opcodes.
  localparam logic OP_START = 1'b0;
  localparam logic OP_BYTE  = 1'b1;

  // Configuration register indexes.
  localparam logic [1:0] CFG_USE_ANNEX_B = 2'd0;
  localparam logic [1:0] CFG_UUID_HIGH   = 2'd1;
  localparam logic [1:0] CFG_UUID_LOW    = 2'd2;

  // Fixed bytes of the unit.
  localparam logic [7:0] NAL_TYPE_SEI        = 8'h06;
  localparam logic [7:0] SEI_USER_DATA_UNREG = 8'h05;
  localparam logic [7:0] SIZE_FILL           = 8'hFF;
  localparam logic [7:0] TRAILING            = 8'h80;
  localparam logic [7:0] START_CODE_LAST     = 8'h01;
  localparam int unsigned UUID_BYTES         = 16;

  // Header byte positions: prefix 0..3, type 4, payload type 5, sizes from 6.
  localparam logic [5:0] HDR_TYPE_POS  = 6'd4;
  localparam logic [5:0] HDR_PTYPE_POS = 6'd5;
  localparam logic [5:0] HDR_SIZE_POS  = 6'd6;
  // Last header byte sits at this offset plus the fill count.
  localparam logic [5:0] HDR_LAST_BASE = 6'd22;

  typedef struct packed {
    logic        opcode;
    logic [11:0] message_length;
    logic [7:0]  message_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       frame_end;
    logic       rejected;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CALC,
    ST_SIZE,
    ST_DECIDE,
    ST_HDR,
    ST_TAIL_ZERO,
    ST_TAIL_END
  } state_t;

  typedef enum logic [2:0] {
    EMIT_NONE,
    EMIT_REJ,
    EMIT_HDR,
    EMIT_BYTE,
    EMIT_TAIL_ZERO,
    EMIT_TAIL_END
  } emit_sel_t;

  typedef struct packed {
    logic      latch_len;
    logic      calc;
    logic      size;
    logic      commit;
    logic      byte_take;
    logic      hdr_clear;
    logic      hdr_inc;
    emit_sel_t emit;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic over;
    logic len_zero;
    logic hdr_last;
    logic tail_two;
    logic byte_pass;
    logic byte_last;
  } status_t;

endpackage

// File: sv/sei_dp.sv
// ----------------------------------------------------------------------------
// SEI framer datapath
// Holds the configuration registers, the per-unit size arithmetic, the
// message counters, the header byte selection and the output register.
// ----------------------------------------------------------------------------
module sei_dp import sei_pkg::*; #(
  parameter int MAX_FRAME_BYTES = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  in_item_t    in_data,
  input  cmd_t        cmd,
  output status_t     sts,
  input  logic        out_ready,
  output logic        out_valid,
  output out_item_t   out_data
);

  localparam logic [12:0] MaxBytes = 13'(MAX_FRAME_BYTES);

  logic         annex_b_r;
  logic [127:0] uuid_r;
  logic [11:0]  len_r;
  logic [12:0]  payload_r;
  logic [4:0]   fills_r;
  logic [7:0]   rem_r;
  logic [12:0]  body_r;
  logic         two_r;
  logic [11:0]  remaining_r, remaining_nxt;
  logic         dropping_r, dropping_nxt;
  logic         tail_two_r, tail_two_nxt;
  logic [5:0]   hdr_idx_r;
  logic         out_valid_r;
  out_item_t    out_r, out_nxt;

  logic [12:0]  payload_c;
  logic [12:0]  fills_c;
  logic [12:0]  body_base_c;
  logic [12:0]  total_c;
  logic [5:0]   rel_c;
  logic [5:0]   fills6_c;
  logic [3:0]   uuid_pos_c;
  logic [7:0]   hdr_byte_c;
  logic         hdr_last_c;

  // Configuration writes; indexes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      annex_b_r <= 1'b1;
      uuid_r    <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_USE_ANNEX_B: annex_b_r <= cfg_data[0];
        CFG_UUID_HIGH:   uuid_r[127:64] <= cfg_data;
        CFG_UUID_LOW:    uuid_r[63:0] <= cfg_data;
        default:         ;
      endcase
    end
  end

  // Size arithmetic. A value below 65535 divided by 255 is
  // (x + 1 + (x >> 8)) >> 8, and the remainder is x + quotient modulo 256.
  assign payload_c   = {1'b0, len_r} + 13'(UUID_BYTES);
  assign fills_c     = (payload_r + 13'd1 + (payload_r >> 8)) >> 8;
  assign body_base_c = payload_r + 13'd3 + {8'd0, fills_c[4:0]};
  assign total_c     = body_r + 13'd4;

  always_ff @(posedge clk) begin
    if (cmd.latch_len) begin
      len_r <= in_data.message_length;
    end
    if (cmd.calc) begin
      payload_r <= payload_c;
    end
    // Body length: the tail is two bytes when the body before the tail is even.
    if (cmd.size) begin
      fills_r <= fills_c[4:0];
      rem_r   <= payload_r[7:0] + fills_c[7:0];
      two_r   <= ~body_base_c[0];
      body_r  <= body_base_c + (body_base_c[0] ? 13'd1 : 13'd2);
    end
  end

  // Message counters and tail flag.
  always_comb begin
    remaining_nxt = remaining_r;
    dropping_nxt  = dropping_r;
    tail_two_nxt  = tail_two_r;
    if (cmd.commit) begin
      remaining_nxt = len_r;
      dropping_nxt  = sts.over && (len_r != 12'd0);
      tail_two_nxt  = sts.over ? 1'b0 : two_r;
    end else if (cmd.byte_take) begin
      if (remaining_r == 12'd0) begin
        dropping_nxt = 1'b0;
      end else begin
        remaining_nxt = remaining_r - 12'd1;
        if (remaining_r == 12'd1) begin
          dropping_nxt = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      remaining_r <= '0;
      dropping_r  <= 1'b0;
      tail_two_r  <= 1'b0;
      hdr_idx_r   <= '0;
    end else begin
      remaining_r <= remaining_nxt;
      dropping_r  <= dropping_nxt;
      tail_two_r  <= tail_two_nxt;
      if (cmd.hdr_clear) begin
        hdr_idx_r <= '0;
      end else if (cmd.hdr_inc) begin
        hdr_idx_r <= hdr_idx_r + 6'd1;
      end
    end
  end

  // Header byte selection by position.
  assign fills6_c   = {1'b0, fills_r};
  assign rel_c      = hdr_idx_r - HDR_SIZE_POS;
  assign uuid_pos_c = 4'(rel_c - fills6_c - 6'd1);
  assign hdr_last_c = (hdr_idx_r == HDR_LAST_BASE + fills6_c);

  always_comb begin
    if (hdr_idx_r < HDR_TYPE_POS) begin
      if (annex_b_r) begin
        hdr_byte_c = (hdr_idx_r == 6'd3) ? START_CODE_LAST : 8'h00;
      end else begin
        case (hdr_idx_r[1:0])
          2'd2:    hdr_byte_c = {3'd0, body_r[12:8]};
          2'd3:    hdr_byte_c = body_r[7:0];
          default: hdr_byte_c = 8'h00;
        endcase
      end
    end else if (hdr_idx_r == HDR_TYPE_POS) begin
      hdr_byte_c = NAL_TYPE_SEI;
    end else if (hdr_idx_r == HDR_PTYPE_POS) begin
      hdr_byte_c = SEI_USER_DATA_UNREG;
    end else if (rel_c < fills6_c) begin
      hdr_byte_c = SIZE_FILL;
    end else if (rel_c == fills6_c) begin
      hdr_byte_c = rem_r;
    end else begin
      hdr_byte_c = uuid_r[{~uuid_pos_c, 3'b000} +: 8];
    end
  end

  // Output register: loads a new result whenever the controller emits one.
  always_comb begin
    out_nxt = '0;
    case (cmd.emit)
      EMIT_REJ: begin
        out_nxt.run_last = 1'b1;
        out_nxt.rejected = 1'b1;
      end
      EMIT_HDR: begin
        out_nxt.out_byte = hdr_byte_c;
        out_nxt.run_last = hdr_last_c && (len_r != 12'd0);
      end
      EMIT_BYTE: begin
        out_nxt.out_byte = in_data.message_byte;
        out_nxt.run_last = (remaining_r != 12'd1);
      end
      EMIT_TAIL_ZERO: begin
        out_nxt.out_byte = 8'h00;
      end
      EMIT_TAIL_END: begin
        out_nxt.out_byte  = TRAILING;
        out_nxt.run_last  = 1'b1;
        out_nxt.frame_end = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit != EMIT_NONE) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit != EMIT_NONE) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Status toward the controller.
  assign sts.out_free  = !out_valid_r || out_ready;
  assign sts.over      = (total_c > MaxBytes);
  assign sts.len_zero  = (len_r == 12'd0);
  assign sts.hdr_last  = hdr_last_c;
  assign sts.tail_two  = tail_two_r;
  assign sts.byte_pass = (remaining_r != 12'd0) && !dropping_r;
  assign sts.byte_last = (remaining_r == 12'd1);

endmodule

// File: sv/sei_ctrl.sv
// ----------------------------------------------------------------------------
// SEI framer controller
// State machine that sequences size calculation, header, message bytes and
// tail, and drives the input handshake and the datapath commands.
// ----------------------------------------------------------------------------
module sei_ctrl import sei_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  input  logic    in_opcode,
  output logic    in_ready,
  input  status_t sts,
  output cmd_t    cmd
);

  state_t state_r, state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.emit  = EMIT_NONE;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = sts.out_free;
        if (in_valid && sts.out_free) begin
          if (in_opcode == OP_START) begin
            cmd.latch_len = 1'b1;
            state_nxt     = ST_CALC;
          end else begin
            cmd.byte_take = 1'b1;
            if (sts.byte_pass) begin
              cmd.emit = EMIT_BYTE;
              if (sts.byte_last) begin
                state_nxt = sts.tail_two ? ST_TAIL_ZERO : ST_TAIL_END;
              end
            end
          end
        end
      end
      ST_CALC: begin
        cmd.calc  = 1'b1;
        state_nxt = ST_SIZE;
      end
      ST_SIZE: begin
        cmd.size  = 1'b1;
        state_nxt = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (sts.over) begin
          if (sts.out_free) begin
            cmd.commit = 1'b1;
            cmd.emit   = EMIT_REJ;
            state_nxt  = ST_IDLE;
          end
        end else begin
          cmd.commit    = 1'b1;
          cmd.hdr_clear = 1'b1;
          state_nxt     = ST_HDR;
        end
      end
      ST_HDR: begin
        if (sts.out_free) begin
          cmd.emit    = EMIT_HDR;
          cmd.hdr_inc = 1'b1;
          if (sts.hdr_last) begin
            if (sts.len_zero) begin
              state_nxt = sts.tail_two ? ST_TAIL_ZERO : ST_TAIL_END;
            end else begin
              state_nxt = ST_IDLE;
            end
          end
        end
      end
      ST_TAIL_ZERO: begin
        if (sts.out_free) begin
          cmd.emit  = EMIT_TAIL_ZERO;
          state_nxt = ST_TAIL_END;
        end
      end
      ST_TAIL_END: begin
        if (sts.out_free) begin
          cmd.emit  = EMIT_TAIL_END;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// File: sv/sei_nal_unit_framer.sv
// Start item: size arithmetic in the calc, size and decide states, then 23
// to 39 header bytes at one byte per cycle while the output is not stalled,
// plus a tail of one or two bytes for an empty message. Message byte items:
// one per cycle while the output is not stalled; each result is registered.
// The single output register sets the pace. Reset (rst_n low, synchronous)
// returns to idle with annex B framing, a zero UUID and no message pending.
// ----------------------------------------------------------------------------
// SEI NAL unit framer
// Builds SEI user-data-unregistered NAL units as a byte stream from start and
// message byte items, with a start code or length prefix and UUID header.
// ----------------------------------------------------------------------------
module sei_nal_unit_framer import sei_pkg::*; #(
  parameter int MAX_FRAME_BYTES = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data
);

  cmd_t    cmd;
  status_t sts;

  // Configuration writes are taken at any time.
  assign cfg_ready = 1'b1;

  sei_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_opcode (in_data.opcode),
    .in_ready  (in_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  sei_dp #(
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

// File: sv/sei_chk.sv
// ----------------------------------------------------------------------------
// SEI framer port checker
// Concurrent assertions on the framer's ports, bound to the top level.
// ----------------------------------------------------------------------------
module sei_chk import sei_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        cfg_valid,
  input logic        cfg_ready,
  input logic [1:0]  cfg_index,
  input logic [63:0] cfg_data,
  input logic        in_valid,
  input logic        in_ready,
  input in_item_t    in_data,
  input logic        out_valid,
  input logic        out_ready,
  input out_item_t   out_data
);

  // A stalled result holds until its transfer.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // A rejection is a lone, empty result.
  a_reject_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.rejected |->
      out_data.run_last && !out_data.frame_end && (out_data.out_byte == 8'h00))
    else $error("malformed rejection");

  // The unit ends on the trailing byte, which closes its item's run.
  a_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.frame_end |->
      out_data.run_last && !out_data.rejected && (out_data.out_byte == TRAILING))
    else $error("unit end without trailing byte");

  // No result is offered in the cycle after reset.
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered out of reset");

endmodule

bind sei_nal_unit_framer sei_chk u_sei_chk (.*);

// File: tb/sei_nal_unit_framer_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// SEI NAL unit framer testbench
// Drives start and message byte transfers into the framer under changing
// prefix and UUID settings, predicts every byte of each unit in a scoreboard,
// and checks the output stream in order with random and long stalls on both
// sides.
// ----------------------------------------------------------------------------
module sei_nal_unit_framer_tb;
  import sei_pkg::*;

  localparam int          MAX_FRAME       = 1024;
  localparam logic [1:0]  CFG_UNUSED      = 2'd3;
  localparam int unsigned SETTLE_CYCLES   = 64;
  localparam int unsigned HOLD_OFF_CYCLES = 300;
  localparam int unsigned WATCHDOG_LIMIT  = 4000;
  localparam int unsigned MAX_REPORTS     = 10;

  // Scoreboard: predicts the bytes of each unit and checks them in order.
  class sei_unit_scoreboard;
    out_item_t   unit_bytes_due[$];
    logic        annex_b;
    logic [63:0] uuid_hi;
    logic [63:0] uuid_lo;
    logic [11:0] msg_left;
    logic        tail_two;
    logic        dropping;
    int unsigned errors;

    function new();
      annex_b  = 1'b1;
      uuid_hi  = '0;
      uuid_lo  = '0;
      msg_left = '0;
      tail_two = 1'b0;
      dropping = 1'b0;
      errors   = 0;
    endfunction

    function int unsigned pending();
      return unit_bytes_due.size();
    endfunction

    function void write_reg(logic [1:0] idx, logic [63:0] val);
      case (idx)
        CFG_USE_ANNEX_B: annex_b = val[0];
        CFG_UUID_HIGH:   uuid_hi = val;
        CFG_UUID_LOW:    uuid_lo = val;
        default: ;
      endcase
    endfunction

    function void add_byte(logic [7:0] b, logic fend = 1'b0, logic rej = 1'b0);
      out_item_t r;
      r.out_byte  = b;
      r.run_last  = 1'b0;
      r.frame_end = fend;
      r.rejected  = rej;
      unit_bytes_due.push_back(r);
    endfunction

    function void add_tail();
      if (tail_two) add_byte(8'h00);
      add_byte(TRAILING, 1'b1);
    endfunction

    // Works out the bytes that one accepted input transfer causes.
    function void note_input(in_item_t it);
      logic [31:0] len;
      logic [31:0] payload;
      logic [31:0] fills;
      logic [31:0] body;
      logic [31:0] size_rem;
      logic        two;
      int          first;
      int          i;
      first = unit_bytes_due.size();
      if (it.opcode == OP_START) begin
        len      = 32'(it.message_length);
        payload  = len + UUID_BYTES;
        fills    = payload / 255;
        size_rem = payload % 255;
        body     = 2 + payload + fills + 1;
        two      = (body % 2 == 0);
        body     = body + (two ? 2 : 1);
        msg_left = it.message_length;
        if (4 + body > MAX_FRAME) begin
          add_byte(8'h00, 1'b0, 1'b1);
          dropping = (len != 0);
          tail_two = 1'b0;
        end else begin
          if (annex_b) begin
            add_byte(8'h00);
            add_byte(8'h00);
            add_byte(8'h00);
            add_byte(START_CODE_LAST);
          end else begin
            for (i = 3; i >= 0; i--) add_byte(body[8*i +: 8]);
          end
          add_byte(NAL_TYPE_SEI);
          add_byte(SEI_USER_DATA_UNREG);
          for (i = 0; i < int'(fills); i++) add_byte(SIZE_FILL);
          add_byte(size_rem[7:0]);
          for (i = 7; i >= 0; i--) add_byte(uuid_hi[8*i +: 8]);
          for (i = 7; i >= 0; i--) add_byte(uuid_lo[8*i +: 8]);
          tail_two = two;
          dropping = 1'b0;
          if (len == 0) add_tail();
        end
      end else if (msg_left == 0) begin
        // A byte with no message open is ignored.
        dropping = 1'b0;
      end else begin
        msg_left = msg_left - 1;
        if (dropping) begin
          if (msg_left == 0) dropping = 1'b0;
        end else begin
          add_byte(it.message_byte);
          if (msg_left == 0) add_tail();
        end
      end
      if (unit_bytes_due.size() > first)
        unit_bytes_due[unit_bytes_due.size() - 1].run_last = 1'b1;
    endfunction

    // Compares one output transfer with the oldest predicted byte.
    function void check_result(out_item_t got);
      out_item_t exp;
      if (unit_bytes_due.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: unexpected output byte=%h last=%b end=%b rej=%b", $realtime,
                   got.out_byte, got.run_last, got.frame_end, got.rejected);
        return;
      end
      exp = unit_bytes_due.pop_front();
      if (got.out_byte !== exp.out_byte || got.run_last !== exp.run_last ||
          got.frame_end !== exp.frame_end || got.rejected !== exp.rejected) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: mismatch byte=%h/%h last=%b/%b end=%b/%b rej=%b/%b (exp/got)",
                   $realtime, exp.out_byte, got.out_byte, exp.run_last, got.run_last,
                   exp.frame_end, got.frame_end, exp.rejected, got.rejected);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [63:0] cfg_data;
  logic        in_valid;
  logic        in_ready;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_ready;
  out_item_t   out_data;

  sei_unit_scoreboard sb;
  int unsigned        send_idle_pct;
  int unsigned        recv_idle_pct;
  int unsigned        items_sent;
  int unsigned        quiet_cycles;
  logic               hold_off_req;

  sei_nal_unit_framer #(.MAX_FRAME_BYTES(MAX_FRAME)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Monitors and watchdog: every transfer is seen with pre-edge values.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
      if (in_valid && in_ready) sb.note_input(in_data);
      if (out_valid && out_ready) sb.check_result(out_data);
      if ((cfg_valid && cfg_ready) || (in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off when requested.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Leaves cfg_valid high; the caller lowers it after the last write.
  task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic configure(input logic annex_b, input logic [63:0] hi, input logic [63:0] lo);
    write_reg(CFG_USE_ANNEX_B, {63'd0, annex_b});
    write_reg(CFG_UUID_HIGH, hi);
    write_reg(CFG_UUID_LOW, lo);
    cfg_valid <= 1'b0;
  endtask

  // One input transfer, with random idle cycles ahead of it.
  task automatic send_item(input logic op, input logic [11:0] len, input logic [7:0] b);
    in_item_t it;
    it.opcode         = op;
    it.message_length = len;
    it.message_byte   = b;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_start(input logic [11:0] len);
    send_item(OP_START, len, 8'($urandom));
  endtask

  task automatic send_byte(input logic [7:0] b);
    send_item(OP_BYTE, 12'($urandom), b);
  endtask

  // The sender stops offering and waits until every predicted byte is out.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic finish_phase();
    in_valid <= 1'b0;
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Mostly complete short messages; some cut short, large or rejected, and
  // some stray bytes.
  task automatic send_random_traffic(input int unsigned count);
    int unsigned stop_at;
    int unsigned kind;
    int unsigned len;
    int unsigned n;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      kind = $urandom_range(99);
      if (kind < 60) begin
        len = $urandom_range(0, 24);
        n   = len;
      end else if (kind < 66) begin
        len = $urandom_range(1, 24);
        n   = $urandom_range(0, len - 1);
      end else if (kind < 77) begin
        len = $urandom_range(225, 290);
        n   = $urandom_range(0, 6);
      end else if (kind < 88) begin
        len = ($urandom_range(1) != 0) ? $urandom_range(990, 1010) : $urandom_range(0, 4095);
        n   = $urandom_range(0, 4);
      end
      if (kind < 88) begin
        send_start(len[11:0]);
        repeat (n) send_byte(8'($urandom));
      end else begin
        repeat ($urandom_range(1, 3)) send_byte(8'($urandom));
      end
    end
  endtask

  initial begin
    sb            = new();
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_data       = '0;
    cfg_valid     = 1'b0;
    cfg_index     = CFG_USE_ANNEX_B;
    cfg_data      = '0;
    hold_off_req  = 1'b0;
    items_sent    = 0;
    quiet_cycles  = 0;
    send_idle_pct = 26;
    recv_idle_pct = 64;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: an index past the register list is ignored.
    write_reg(CFG_UNUSED, '1);
    configure(1'b1, 64'h0011_2233_4455_6677, '1);
    send_start(12'd0);
    send_byte(8'hAA);
    send_start(12'd1);
    send_byte(8'h00);
    send_start(12'd2);
    send_byte(8'hFF);
    send_byte(8'h5A);
    // Start during a message abandons the open unit.
    send_start(12'd3);
    send_byte(8'h01);
    send_start(12'd239);
    send_byte(8'h80);
    send_start(12'd238);
    send_byte(8'h3C);
    // Largest accepted unit, then the first rejected one.
    send_start(12'd997);
    send_byte(8'h7F);
    send_start(12'd998);
    send_byte(8'h11);
    send_start(12'hFFF);
    send_start(12'd0);
    // A rejected unit with some dropped bytes, cut off by an empty unit,
    // then a stray byte.
    send_start(12'd998);
    repeat (6) send_byte(8'($urandom));
    send_start(12'd0);
    send_byte(8'hC3);
    finish_phase();

    // Sender idles less than the receiver; one long receiver hold-off.
    configure(1'b0, '1, '0);
    send_random_traffic(35);
    hold_off_req = 1'b1;
    send_random_traffic(100);
    finish_phase();

    // Receiver idles less than the sender; one pause until all bytes are out.
    send_idle_pct = 64;
    recv_idle_pct = 26;
    configure(1'b1, {$urandom, $urandom}, {$urandom, $urandom});
    send_random_traffic(65);
    wait_drained();
    send_random_traffic(65);
    finish_phase();

    // No idling on either side.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    configure(1'b0, {$urandom, $urandom}, {$urandom, $urandom});
    send_random_traffic(130);
    finish_phase();

    sb.errors += sb.pending();
    if (sb.errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// File: sim.f
sv/sei_pkg.sv
sv/sei_dp.sv
sv/sei_ctrl.sv
sv/sei_nal_unit_framer.sv
sv/sei_chk.sv
tb/sei_nal_unit_framer_tb.sv
